// ----- rtl/cem_pkg.sv -----
// Shared types and constants for the cron entry matcher.
// Holds the stored job entry layout and the unpacking of a loaded entry word.
// No dependencies.
package cem_pkg;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	localparam logic [6:0] DOW_MASK = 7'h7f;

	typedef struct packed {
		logic       en;
		logic [6:0] dow;
		logic [4:0] hh;
		logic [5:0] mm;
		logic [1:0] rt;
		logic [8:0] val;
	} job_entry_t;

	// Unpack a loaded word: en[31], dow[30:24], hh[23:19], mm[18:13], rt[12:11], val[8:0].
	function automatic job_entry_t unpack_entry(input logic [31:0] w);
		job_entry_t e;
		e.en  = w[31];
		e.dow = w[30:24] & DOW_MASK;
		e.hh  = w[23:19];
		e.mm  = w[18:13];
		e.rt  = w[12:11];
		e.val = w[8:0];
		return e;
	endfunction

endpackage

// ----- rtl/cron_entry_matcher_core.sv -----
// Cron entry matcher: job table in a synchronous memory, scanned one entry a cycle.
// Depends on cem_pkg for the entry layout and function codes.
// Write request, or tick with clock_valid low: busy in FLUSH only, its single result (not fired, last) follows.
// Tick request with clock_valid high: busy through SCAN (one memory read per entry), WAIT and FLUSH;
// matched results stream out during the scan, at most one per cycle, the final one when busy drops.
// The receiver cannot stall. Reset clears control state and the per-entry valid bits,
// so every entry reads as disabled until written; no clearing pass is needed.
module cron_entry_matcher_core #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [3:0]  entry_index,
	input  logic [31:0] entry_word,
	input  logic [2:0]  weekday,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic        clock_valid,
	output logic        done,
	output logic        fired,
	output logic [3:0]  job_index,
	output logic [1:0]  routine,
	output logic [8:0]  job_value,
	output logic        last
);
	import cem_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;

	logic [29:0]        mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;

	logic [IW-1:0] cnt_q;
	logic [2:0]    wd_q;
	logic [4:0]    hr_q;
	logic [5:0]    mn_q;

	logic          rd_vld_s1;
	logic          rd_last_s1;
	logic          ent_vld_s1;
	logic [IW-1:0] idx_s1;
	logic [29:0]   rd_data_s1;

	logic          pend_vld_q;
	logic [IW-1:0] pend_idx_q;
	logic [1:0]    pend_rt_q;
	logic [8:0]    pend_val_q;

	logic          done_q;
	logic          fired_q;
	logic [3:0]    job_index_q;
	logic [1:0]    routine_q;
	logic [8:0]    job_value_q;
	logic          last_q;

	logic          accept;
	logic          wr_ok;
	logic [IW+3:0] wr_ext;
	logic [IW-1:0] wr_addr;
	logic          issue;
	logic          issue_last;
	job_entry_t    ent_s1;
	logic [7:0]    dow_ext;
	logic          hit_s1;
	logic [IW+3:0] pend_idx_ext;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign wr_ok      = (32'(entry_index) < ENTRIES);
	assign wr_ext     = (IW+4)'(entry_index);
	assign wr_addr    = wr_ext[IW-1:0];
	assign issue      = (state_q == ST_SCAN);
	assign issue_last = issue && (cnt_q == IW'(ENTRIES - 1));

	assign ent_s1       = job_entry_t'(rd_data_s1);
	assign dow_ext      = {1'b0, ent_s1.dow};
	assign hit_s1       = rd_vld_s1 && ent_vld_s1 && ent_s1.en && dow_ext[wd_q]
		&& (ent_s1.hh == hr_q) && (ent_s1.mm == mn_q);
	assign pend_idx_ext = (IW+4)'(pend_idx_q);

	// Table memory: write on an accepted write request, read one entry per scan cycle.
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_WRITE) && wr_ok) begin
			mem[wr_addr] <= 30'(unpack_entry(entry_word));
		end
		if (issue) begin
			rd_data_s1 <= mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (accept && (func == FUNC_WRITE) && wr_ok) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wd_q <= weekday;
			hr_q <= hour;
			mn_q <= minute;
		end
		if (issue) begin
			ent_vld_s1 <= vld_q[cnt_q];
			idx_s1     <= cnt_q;
			rd_last_s1 <= issue_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (func == FUNC_TICK && clock_valid) ? ST_SCAN : ST_FLUSH;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (issue_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the latest match back one step so the final one can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (state_q == ST_FLUSH) begin
				done_q     <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (hit_s1) begin
				done_q     <= pend_vld_q;
				pend_vld_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FLUSH) begin
			fired_q     <= pend_vld_q;
			job_index_q <= pend_vld_q ? pend_idx_ext[3:0] : 4'd0;
			routine_q   <= pend_vld_q ? pend_rt_q : 2'd0;
			job_value_q <= pend_vld_q ? pend_val_q : 9'd0;
			last_q      <= 1'b1;
		end else if (hit_s1) begin
			fired_q     <= 1'b1;
			job_index_q <= pend_idx_ext[3:0];
			routine_q   <= pend_rt_q;
			job_value_q <= pend_val_q;
			last_q      <= 1'b0;
			pend_idx_q  <= idx_s1;
			pend_rt_q   <= ent_s1.rt;
			pend_val_q  <= ent_s1.val;
		end
	end

	assign done      = done_q;
	assign fired     = fired_q;
	assign job_index = job_index_q;
	assign routine   = routine_q;
	assign job_value = job_value_q;
	assign last      = last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && last_q) |-> !busy)
		else $error("final result while still busy");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("pending match left over after a run");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_WAIT))
		else $error("read data returned outside a scan");

	a_nofire_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !fired_q) |-> last_q)
		else $error("not-fired result without last");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for cron_entry_matcher_core: table writes and minute-tick scans.
// Predicts every result from its own copy of the job table; uses cem_pkg for codes and layout.
module tb_top;
	import cem_pkg::*;

	localparam int ENTRIES      = 16;
	localparam int DRAIN_CYCLES = ENTRIES + 6;
	localparam int DRAIN_LIMIT  = 400;
	localparam int PHASES       = 4;
	localparam int PHASE_ITEMS  = 80;

	typedef struct packed {
		logic       fired;
		logic [3:0] idx;
		logic [1:0] rt;
		logic [8:0] val;
		logic       last;
	} sched_result_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        func        = FUNC_WRITE;
	logic [3:0]  entry_index = '0;
	logic [31:0] entry_word  = '0;
	logic [2:0]  weekday     = '0;
	logic [4:0]  hour        = '0;
	logic [5:0]  minute      = '0;
	logic        clock_valid = 1'b0;
	logic        busy;
	logic        done;
	logic        fired;
	logic [3:0]  job_index;
	logic [1:0]  routine;
	logic [8:0]  job_value;
	logic        last;

	job_entry_t    sched_table [ENTRIES];
	sched_result_t pending_results [$];
	int            error_count = 0;

	cron_entry_matcher_core #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.entry_index(entry_index),
		.entry_word (entry_word),
		.weekday    (weekday),
		.hour       (hour),
		.minute     (minute),
		.clock_valid(clock_valid),
		.done       (done),
		.fired      (fired),
		.job_index  (job_index),
		.routine    (routine),
		.job_value  (job_value),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

	// Apply one request to the local table and queue the results it should produce.
	function automatic void predict_schedule(input logic f, input logic [3:0] idx,
			input logic [31:0] w, input logic [2:0] wd, input logic [4:0] hr,
			input logic [5:0] mn, input logic cv);
		logic [ENTRIES-1:0] hits;
		sched_result_t      r;
		hits = '0;
		if (f == FUNC_WRITE) begin
			if (idx < ENTRIES) begin
				sched_table[idx].en  = w[31];
				sched_table[idx].dow = w[30:24];
				sched_table[idx].hh  = w[23:19];
				sched_table[idx].mm  = w[18:13];
				sched_table[idx].rt  = w[12:11];
				sched_table[idx].val = w[8:0];
			end
		end else if (cv) begin
			for (int i = 0; i < ENTRIES; i++) begin
				// weekday 7 has no mask bit
				if (sched_table[i].en && wd < 3'd7 && sched_table[i].dow[wd]
						&& sched_table[i].hh == hr && sched_table[i].mm == mn)
					hits[i] = 1'b1;
			end
		end
		if (hits == '0) begin
			r = '{fired: 1'b0, idx: 4'd0, rt: 2'd0, val: 9'd0, last: 1'b1};
			pending_results.push_back(r);
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hits[i]) begin
					r.fired = 1'b1;
					r.idx   = 4'(i);
					r.rt    = sched_table[i].rt;
					r.val   = sched_table[i].val;
					r.last  = ((hits >> (i + 1)) == '0);
					pending_results.push_back(r);
				end
			end
		end
	endfunction

	function automatic logic [31:0] make_word(input logic en, input logic [6:0] dow,
			input logic [4:0] hh, input logic [5:0] mm, input logic [1:0] rt,
			input logic [8:0] val);
		logic [31:0] w;
		w = $urandom;  // keep the ignored pad bits random
		w[31]    = en;
		w[30:24] = dow;
		w[23:19] = hh;
		w[18:13] = mm;
		w[12:11] = rt;
		w[8:0]   = val;
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: fired %0b job_index %0d", fired, job_index);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("fired", exp_r.fired, fired);
				check_field("job_index", exp_r.idx, job_index);
				check_field("routine", exp_r.rt, routine);
				check_field("job_value", exp_r.val, job_value);
				check_field("last", exp_r.last, last);
			end
		end
	end

	// Hold the request until it is taken; leave start high for a following request.
	task automatic send_item(input logic f, input logic [3:0] idx, input logic [31:0] w,
			input logic [2:0] wd, input logic [4:0] hr, input logic [5:0] mn,
			input logic cv);
		@(negedge clk);
		start       <= 1'b1;
		func        <= f;
		entry_index <= idx;
		entry_word  <= w;
		weekday     <= wd;
		hour        <= hr;
		minute      <= mn;
		clock_valid <= cv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_schedule(f, idx, w, wd, hr, mn, cv);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start       <= 1'b0;
			func        <= 1'($urandom);
			entry_index <= 4'($urandom);
			entry_word  <= $urandom;
			weekday     <= 3'($urandom);
			hour        <= 5'($urandom);
			minute      <= 6'($urandom);
			clock_valid <= 1'($urandom);
		end
	endtask

	task automatic wait_results_drained();
		int waited;
		idle_cycles(1);
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
			pending_results.delete();
		end
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd0, 5'd0, 6'd0, 1'b1);
		send_item(FUNC_TICK, 4'd15, 32'hffffffff, 3'd6, 5'd23, 6'd59, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_field_extremes();
		send_item(FUNC_WRITE, 4'd15, 32'hffffffff, 3'd0, 5'd0, 6'd0, 1'b0);
		// out-of-range hour and minute still match on equality
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd7, 5'd31, 6'd63, 1'b1);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd6, 5'd31, 6'd63, 1'b1);
		send_item(FUNC_WRITE, 4'd0, make_word(1'b1, 7'h01, 5'd0, 6'd0, 2'd0, 9'd0),
			3'd0, 5'd0, 6'd0, 1'b0);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd0, 5'd0, 6'd0, 1'b1);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd0, 5'd0, 6'd0, 1'b0);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd1, 5'd0, 6'd0, 1'b1);
		send_item(FUNC_WRITE, 4'd0, 32'h0, 3'd0, 5'd0, 6'd0, 1'b1);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd0, 5'd0, 6'd0, 1'b1);
		send_item(FUNC_WRITE, 4'd15, 32'h7fffffff, 3'd7, 5'd31, 6'd63, 1'b1);
		send_item(FUNC_TICK, 4'd0, 32'h0, 3'd6, 5'd31, 6'd63, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_all_entries_fire();
		for (int i = 0; i < ENTRIES; i++)
			send_item(FUNC_WRITE, 4'(i),
				make_word(1'b1, 7'h7f, 5'd12, 6'd30, 2'(i), 9'($urandom)),
				3'($urandom), 5'($urandom), 6'($urandom), 1'($urandom));
		send_item(FUNC_TICK, 4'($urandom), $urandom, 3'd3, 5'd12, 6'd30, 1'b1);
		send_item(FUNC_TICK, 4'($urandom), $urandom, 3'd3, 5'd12, 6'd31, 1'b1);
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		logic [4:0] pool_hh [3];
		logic [5:0] pool_mm [3];
		logic [31:0] w;
		logic [2:0]  wd;
		int kind;
		int k;
		int burst_left;
		burst_left = 0;
		for (int p = 0; p < PHASES; p++) begin
			for (int j = 0; j < 3; j++) begin
				pool_hh[j] = 5'($urandom_range(0, 23));
				pool_mm[j] = 6'($urandom_range(0, 59));
			end
			if (p == 0) begin
				pool_hh[0] = 5'd0;
				pool_mm[0] = 6'd0;
				pool_hh[1] = 5'd23;
				pool_mm[1] = 6'd59;
				pool_hh[2] = 5'd31;
				pool_mm[2] = 6'd63;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					idle_cycles($urandom_range(0, 8));
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;
				kind = $urandom_range(0, 99);
				k = $urandom_range(0, 2);
				if (kind < 40) begin
					w = make_word($urandom_range(0, 9) != 0, 7'($urandom), pool_hh[k],
						pool_mm[k], 2'($urandom), 9'($urandom));
					if (kind < 4)
						w = $urandom;
					send_item(FUNC_WRITE, 4'($urandom), w, 3'($urandom), 5'($urandom),
						6'($urandom), 1'($urandom));
				end else if (kind < 90) begin
					wd = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
					send_item(FUNC_TICK, 4'($urandom), $urandom, wd, pool_hh[k], pool_mm[k],
						$urandom_range(0, 9) != 0);
				end else begin
					send_item(FUNC_TICK, 4'($urandom), $urandom, 3'($urandom),
						5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
						1'($urandom));
				end
			end
			// let every pending result come out before the next phase
			wait_results_drained();
			burst_left = 0;
		end
	endtask

	initial begin
		foreach (sched_table[i])
			sched_table[i] = '0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		test_empty_table();
		test_field_extremes();
		test_all_entries_fire();
		test_random_traffic();

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cem_pkg.sv
rtl/cron_entry_matcher_core.sv
sim/tb_top.sv
